### src/ascii_range_frame_parser_core_macros.svh
// Assertion macros of the frame parser, used by arfp_back.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASCII_RANGE_FRAME_PARSER_CORE_MACROS_SVH
`define ASCII_RANGE_FRAME_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/arfp_pkg.sv
// Types and constants of the range-finder frame parser.
// No dependencies; used by arfp_front, arfp_back and the top level.
`timescale 1ns / 1ps

package arfp_pkg;

    localparam int FRAME_LEN = 11;
    localparam int FILL_W    = 4;
    localparam int HDR_SLOTS = 9;
    localparam int CM_W      = 17;
    localparam int DIST_W    = 19;
    localparam int CFG_IDX_W = 1;

    localparam logic [FILL_W-1:0] FRAME_FULL = 4'd11;
    localparam logic [FILL_W-1:0] NO_HDR_POS = 4'd9;
    localparam logic [FILL_W-1:0] DOT_POS    = 4'd6;
    localparam logic [FILL_W-1:0] LAST_SUM   = 4'd9;
    localparam logic [FILL_W-1:0] CSUM_POS   = 4'd10;

    localparam logic [7:0] HDR0       = 8'h80;
    localparam logic [7:0] HDR1       = 8'h06;
    localparam logic [7:0] HDR2       = 8'h83;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;

    localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;

    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_CSUM    = 2'd1;
    localparam logic [1:0] STATUS_FORMAT  = 2'd2;
    localparam logic [1:0] STATUS_NO_DATA = 2'd3;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CM    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICK = 1'b1;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic  vld;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [15:0] offset_cm;
        logic [31:0] timeout_ticks;
    } cfg_t;

endpackage

### src/arfp_front.sv
// Front end: accepts words, tags them as byte or tick, and queues them.
// Depends on arfp_pkg.
`timescale 1ns / 1ps

module arfp_front #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [7:0]            rx_byte,
    input  logic                  pop,
    output arfp_pkg::queue_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    arfp_pkg::item_t q_mem [DEPTH];
    arfp_pkg::item_t in_item;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pull;

    assign in_stall = (count_reg == CNT_FULL);
    assign push     = in_valid && !in_stall;
    assign pull     = pop && (count_reg != '0);

    always_comb
    begin
        in_item.is_tick = (func == arfp_pkg::KIND_TICK);
        in_item.data    = rx_byte;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pull})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    assign head.vld  = (count_reg != '0);
    assign head.item = q_mem[rd_ptr_reg];

endmodule

### src/arfp_back.sv
// Back end: frame buffer, header search, checksum and format pass,
// idle tick counter and the output register. Depends on arfp_pkg.
`timescale 1ns / 1ps
`include "ascii_range_frame_parser_core_macros.svh"

module arfp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  arfp_pkg::queue_head_t head,
    output logic                  pop,
    input  arfp_pkg::cfg_t        cfg,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic signed [18:0]    range_cm
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    localparam int FL = arfp_pkg::FRAME_LEN;
    localparam int FW = arfp_pkg::FILL_W;
    localparam int CW = arfp_pkg::CM_W;
    localparam int DW = arfp_pkg::DIST_W;
    localparam int HDR_BITS = arfp_pkg::HDR_SLOTS;

    logic [2:0]    state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [31:0]   idle_reg, idle_next;
    logic          reported_reg, reported_next;
    logic          out_valid_reg, out_valid_next;

    logic [7:0]    frame_reg [FL];
    logic [7:0]    frame_next [FL];
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic [CW-1:0] cm_reg, cm_next;
    logic          fmt_bad_reg, fmt_bad_next;
    logic [1:0]    status_reg, status_next;
    logic [DW-1:0] dist_reg, dist_next;

    logic                 slot_free;
    logic                 emit_nodata;
    logic [FW-1:0]        wr_idx;
    logic [HDR_BITS-1:0]  hit;
    logic [FW-1:0]        hdr_pos;
    logic [7:0]           cur_byte;
    logic                 cur_digit;
    logic [CW-1:0]        cm_x10;
    logic                 csum_ok;
    logic [1:0]           frame_status;

    assign slot_free   = !out_valid_reg || !out_stall;
    assign emit_nodata = (state_reg == S_TICK) && !reported_reg
                         && (idle_reg >= cfg.timeout_ticks) && slot_free;

    // Header flags at every fixed offset; the lowest hit wins.
    always_comb
    begin
        for (int p = 0; p < HDR_BITS; p++)
        begin
            hit[p] = (frame_reg[p] == arfp_pkg::HDR0) && (frame_reg[p+1] == arfp_pkg::HDR1)
                     && (frame_reg[p+2] == arfp_pkg::HDR2);
        end
        hdr_pos = arfp_pkg::NO_HDR_POS;
        for (int p = HDR_BITS - 1; p >= 0; p--)
        begin
            if (hit[p])
            begin
                hdr_pos = FW'(p);
            end
        end
    end

    always_comb
    begin
        cur_byte = '0;
        for (int i = 0; i < FL; i++)
        begin
            if (idx_reg == FW'(i))
            begin
                cur_byte = frame_reg[i];
            end
        end
        cur_digit = (cur_byte >= arfp_pkg::ASCII_ZERO) && (cur_byte <= arfp_pkg::ASCII_NINE);
        cm_x10    = {cm_reg[CW-4:0], 3'b000} + {cm_reg[CW-2:0], 1'b0};
        csum_ok   = (8'(frame_reg[FL-1] + sum_reg) == 8'h00);
        if (!csum_ok)
        begin
            frame_status = arfp_pkg::STATUS_CSUM;
        end
        else if (fmt_bad_reg)
        begin
            frame_status = arfp_pkg::STATUS_FORMAT;
        end
        else
        begin
            frame_status = arfp_pkg::STATUS_GOOD;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idle_next      = idle_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg && out_stall;
        frame_next     = frame_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        cm_next        = cm_reg;
        fmt_bad_next   = fmt_bad_reg;
        status_next    = status_reg;
        dist_next      = dist_reg;
        pop            = 1'b0;
        wr_idx         = (fill_reg >= arfp_pkg::FRAME_FULL) ? '0 : fill_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (head.vld)
                begin
                    pop = 1'b1;
                    if (head.item.is_tick)
                    begin
                        if (idle_reg != '1)
                        begin
                            idle_next = idle_reg + 1'b1;
                        end
                        state_next = S_TICK;
                    end
                    else
                    begin
                        for (int i = 0; i < FL; i++)
                        begin
                            if (wr_idx == FW'(i))
                            begin
                                frame_next[i] = head.item.data;
                            end
                        end
                        fill_next = wr_idx + 1'b1;
                        if (wr_idx + 1'b1 == arfp_pkg::FRAME_FULL)
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                end
            end
            S_TICK:
            begin
                if (!reported_reg && (idle_reg >= cfg.timeout_ticks))
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = arfp_pkg::STATUS_NO_DATA;
                        dist_next      = '0;
                        reported_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (hdr_pos == '0)
                begin
                    idx_next     = '0;
                    sum_next     = '0;
                    cm_next      = '0;
                    fmt_bad_next = 1'b0;
                    state_next   = S_SUM;
                end
                else
                begin
                    pos_next   = hdr_pos;
                    idx_next   = hdr_pos;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // One byte toward offset zero per cycle.
                for (int i = 0; i < FL - 1; i++)
                begin
                    frame_next[i] = frame_reg[i+1];
                end
                idx_next = idx_reg - 1'b1;
                if (idx_reg == FW'(1))
                begin
                    fill_next  = arfp_pkg::FRAME_FULL - pos_reg;
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                // Byte sum over bytes 0 to 9; the DDD.DDD check covers bytes 3 to 9.
                sum_next = sum_reg + cur_byte;
                if (idx_reg == arfp_pkg::DOT_POS)
                begin
                    if (cur_byte != arfp_pkg::ASCII_DOT)
                    begin
                        fmt_bad_next = 1'b1;
                    end
                end
                else if (idx_reg inside {4'd3, 4'd4, 4'd5, 4'd7, 4'd8, 4'd9})
                begin
                    if (!cur_digit)
                    begin
                        fmt_bad_next = 1'b1;
                    end
                end
                // The last digit is dropped, which is the divide by ten.
                if (idx_reg inside {4'd3, 4'd4, 4'd5, 4'd7, 4'd8})
                begin
                    cm_next = cm_x10 + CW'(cur_byte[3:0]);
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == arfp_pkg::LAST_SUM)
                begin
                    fill_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = frame_status;
                    if (frame_status == arfp_pkg::STATUS_GOOD)
                    begin
                        dist_next     = {2'b00, cm_reg}
                                        + {{(DW-16){cfg.offset_cm[15]}}, cfg.offset_cm};
                        idle_next     = '0;
                        reported_next = 1'b0;
                    end
                    else
                    begin
                        dist_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idle_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idle_reg      <= idle_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg   <= frame_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        sum_reg     <= sum_next;
        cm_reg      <= cm_next;
        fmt_bad_reg <= fmt_bad_next;
        status_reg  <= status_next;
        dist_reg    <= dist_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign range_cm  = dist_reg;

    `ARFP_ASSERT_SAME(a_err_has_zero_dist, out_valid_reg && (status_reg != arfp_pkg::STATUS_GOOD), dist_reg == '0, "bad status with nonzero distance")
    `ARFP_ASSERT_SAME(a_pop_only_when_idle, pop, (state_reg == S_IDLE) && head.vld, "queue popped outside idle")
    `ARFP_ASSERT_SAME(a_full_while_scanning, (state_reg == S_SEARCH) || (state_reg == S_SHIFT) || (state_reg == S_SUM), fill_reg == arfp_pkg::FRAME_FULL, "frame pass without a full buffer")
    `ARFP_ASSERT_NEXT(a_nodata_reported, emit_nodata, out_valid_reg && reported_reg && (status_reg == arfp_pkg::STATUS_NO_DATA), "timeout result not registered")

endmodule

### src/ascii_range_frame_parser_core.sv
// Channel   Signals                         Direction   Handshake
// input     func, rx_byte                   in          in_valid / in_stall
// result    status, range_cm                out         out_valid / out_stall
// config    cfg_index, cfg_data             in          cfg_valid / cfg_ready
//
// A byte that does not complete the buffer is taken in the idle state; a tick
// also passes through the tick state. The byte that fills the buffer adds a
// header search, then either shifting by pos bytes (pos = header offset, 9 when
// none) or the serial checksum and digit pass plus the result write.
// Reset leaves the buffer contents undefined; only a full buffer is ever read.
// A queue of QUEUE_DEPTH words lets input keep flowing while a result is stalled.
// Depends on arfp_pkg, arfp_front and arfp_back.
`timescale 1ns / 1ps

module ascii_range_frame_parser_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [18:0]                range_cm,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);

    logic [15:0] offset_reg, offset_next;
    logic [31:0] timeout_reg, timeout_next;
    logic        cfg_write;

    arfp_pkg::queue_head_t head;
    arfp_pkg::cfg_t        cfg;
    logic                  pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        offset_next  = offset_reg;
        timeout_next = timeout_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                arfp_pkg::REG_OFFSET_CM:    offset_next  = cfg_data[15:0];
                arfp_pkg::REG_TIMEOUT_TICK: timeout_next = cfg_data;
                default:
                begin
                    offset_next  = offset_reg;
                    timeout_next = timeout_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            timeout_reg <= arfp_pkg::TIMEOUT_RESET;
        end
        else
        begin
            offset_reg  <= offset_next;
            timeout_reg <= timeout_next;
        end
    end

    assign cfg.offset_cm     = offset_reg;
    assign cfg.timeout_ticks = timeout_reg;

    arfp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .rx_byte  (rx_byte),
        .pop      (pop),
        .head     (head)
    );

    arfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .range_cm  (range_cm)
    );

endmodule

### dv/range_reading_checker.sv
// Scoreboard for the range-finder frame parser: it watches the input, result and
// configuration channels, predicts every result word and compares it with the output.
// Depends on arfp_pkg.
`timescale 1ns / 1ps

module range_reading_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           func,
    input  logic [7:0]                     rx_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [1:0]                     status,
    input  logic [18:0]                    range_cm,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [arfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             mismatches,
    output int                             pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [18:0] cm;
    } reading_t;

    reading_t    readings_due[$];
    logic [7:0]  frame_bytes[0:arfp_pkg::FRAME_LEN-1];
    logic [3:0]  held;
    logic [31:0] ticks_idle;
    logic        no_data_sent;
    logic [15:0] offset_reg;
    logic [31:0] timeout_reg;
    int          fail_tally = 0;

    assign mismatches = fail_tally;

    // Grades the full buffer: checksum first, then the dot and the six digits.
    function automatic reading_t grade_frame();
        reading_t   r;
        logic [7:0] sum;
        logic [7:0] c;
        int         mm;
        int         k;
        sum = '0;
        mm = 0;
        r.status = arfp_pkg::STATUS_GOOD;
        r.cm = '0;
        for (k = 0; k < arfp_pkg::FRAME_LEN - 1; k++)
            sum = sum + frame_bytes[k];
        if (frame_bytes[arfp_pkg::FRAME_LEN-1] != 8'(~sum + 8'd1))
            r.status = arfp_pkg::STATUS_CSUM;
        else if (frame_bytes[6] != arfp_pkg::ASCII_DOT)
            r.status = arfp_pkg::STATUS_FORMAT;
        else
        begin
            for (k = 3; k < arfp_pkg::FRAME_LEN - 1; k++)
            begin
                c = frame_bytes[k];
                if (k == 6)
                    continue;
                if (c < arfp_pkg::ASCII_ZERO || c > arfp_pkg::ASCII_NINE)
                    r.status = arfp_pkg::STATUS_FORMAT;
                else
                    mm = mm * 10 + int'(c - arfp_pkg::ASCII_ZERO);
            end
            if (r.status == arfp_pkg::STATUS_GOOD)
                r.cm = 19'((mm & 'hFFFFF) / 10 + int'($signed(offset_reg)));
        end
        return r;
    endfunction

    task automatic absorb_word(input logic kind, input logic [7:0] b);
        reading_t r;
        int       hdr;
        int       p;
        if (kind == arfp_pkg::KIND_TICK)
        begin
            if (ticks_idle != '1)
                ticks_idle++;
            if (!no_data_sent && ticks_idle >= timeout_reg)
            begin
                no_data_sent = 1'b1;
                r.status = arfp_pkg::STATUS_NO_DATA;
                r.cm = '0;
                readings_due.push_back(r);
            end
        end
        else
        begin
            frame_bytes[held] = b;
            held++;
            if (held == arfp_pkg::FRAME_FULL)
            begin
                // Offset 9 stands for no header: the last two bytes are kept.
                hdr = 9;
                for (p = 8; p >= 0; p--)
                    if (frame_bytes[p] == arfp_pkg::HDR0 && frame_bytes[p+1] == arfp_pkg::HDR1 &&
                        frame_bytes[p+2] == arfp_pkg::HDR2)
                        hdr = p;
                if (hdr == 0)
                begin
                    held = '0;
                    r = grade_frame();
                    if (r.status == arfp_pkg::STATUS_GOOD)
                    begin
                        ticks_idle = '0;
                        no_data_sent = 1'b0;
                    end
                    readings_due.push_back(r);
                end
                else
                begin
                    for (p = 0; p < arfp_pkg::FRAME_LEN - hdr; p++)
                        frame_bytes[p] = frame_bytes[p+hdr];
                    held = 4'(arfp_pkg::FRAME_LEN - hdr);
                end
            end
        end
    endtask

    task automatic check_reading();
        reading_t want;
        if (readings_due.size() == 0)
        begin
            $error("unexpected result word: status %0d, range_cm %0d",
                   status, $signed(range_cm));
            fail_tally++;
        end
        else
        begin
            want = readings_due.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                fail_tally++;
            end
            if (range_cm !== want.cm)
            begin
                $error("range_cm: expected %0d, actual %0d",
                       $signed(want.cm), $signed(range_cm));
                fail_tally++;
            end
        end
    endtask

    // A result word leaving at the same edge always belongs to an older input word,
    // so it is checked before the new input word is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg = '0;
            timeout_reg = arfp_pkg::TIMEOUT_RESET;
            held = '0;
            ticks_idle = '0;
            no_data_sent = 1'b0;
            readings_due.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_reading();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == arfp_pkg::REG_OFFSET_CM)
                    offset_reg = cfg_data[15:0];
                else
                    timeout_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                absorb_word(func, rx_byte);
            pending <= readings_due.size();
        end
    end

endmodule

### dv/ascii_range_frame_parser_core_tb.sv
// Top of the frame parser testbench: clock, reset, byte and tick stimulus,
// configuration writes and the verdict. Depends on arfp_pkg,
// ascii_range_frame_parser_core and range_reading_checker.
`timescale 1ns / 1ps

module ascii_range_frame_parser_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ITEM_TARGET    = 1250;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           func;
    logic [7:0]                     rx_byte;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     status;
    logic signed [18:0]             range_cm;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [arfp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    int         mismatches;
    int         pending;
    logic [7:0] frm[0:arfp_pkg::FRAME_LEN-1];
    int         burst_left;
    int         gap_max;
    int         sent_items;
    int         chunks_left;
    int         idle_cycles = 0;
    int         stall_mode = 0;
    int         stall_run = 0;

    ascii_range_frame_parser_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .range_cm  (range_cm),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    range_reading_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .range_cm   (range_cm),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The receiver switches between stretches of no stalls, light, heavy and
    // near-permanent stalling.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(16, 200);
            end
            else
                stall_run--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= $urandom_range(0, 1);
                default: out_stall <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // After the write word, valid goes low and the task waits for a clock edge, so
    // back-to-back writes never drive valid twice at the same edge.
    task automatic write_reg(input logic [arfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sends one word; valid stays high across a burst and drops for a random gap
    // between bursts when gap_max is above zero.
    task automatic send_item(input logic kind, input logic [7:0] b);
        if (burst_left == 0)
        begin
            if (gap_max > 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        func <= kind;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        sent_items++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Brings the block to rest before a configuration write: every result in,
    // then time for a word that produces no result to finish.
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic seal_frame();
        logic [7:0] sum;
        int         k;
        sum = '0;
        for (k = 0; k < arfp_pkg::FRAME_LEN - 1; k++)
            sum = sum + frm[k];
        frm[arfp_pkg::FRAME_LEN-1] = ~sum + 8'd1;
    endtask

    task automatic make_frame(input int mm);
        int rest;
        int k;
        rest = mm;
        frm[0] = arfp_pkg::HDR0;
        frm[1] = arfp_pkg::HDR1;
        frm[2] = arfp_pkg::HDR2;
        frm[6] = arfp_pkg::ASCII_DOT;
        for (k = 9; k >= 3; k--)
        begin
            if (k != 6)
            begin
                frm[k] = arfp_pkg::ASCII_ZERO + 8'(rest % 10);
                rest = rest / 10;
            end
        end
        seal_frame();
    endtask

    task automatic send_span(input int lo, input int hi);
        int k;
        for (k = lo; k <= hi; k++)
            send_item(arfp_pkg::KIND_BYTE, frm[k]);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(arfp_pkg::KIND_TICK, 8'($urandom));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_item(arfp_pkg::KIND_BYTE, 8'($urandom));
    endtask

    task automatic make_bad_format();
        int         k;
        logic [7:0] b;
        k = $urandom_range(3, 9);
        do
            b = 8'($urandom);
        while ((k == 6) ? (b == arfp_pkg::ASCII_DOT) :
               (b >= arfp_pkg::ASCII_ZERO && b <= arfp_pkg::ASCII_NINE));
        frm[k] = b;
        seal_frame();
    endtask

    task automatic random_chunk();
        case ($urandom_range(0, 10))
            0, 1, 2:
            begin
                case ($urandom_range(0, 7))
                    0: make_frame(0);
                    1: make_frame(999999);
                    default: make_frame($urandom_range(0, 999999));
                endcase
                send_span(0, 10);
            end
            3:
            begin
                make_frame($urandom_range(0, 999999));
                frm[10] = frm[10] + 8'($urandom_range(1, 255));
                send_span(0, 10);
            end
            4:
            begin
                make_frame($urandom_range(0, 999999));
                make_bad_format();
                send_span(0, 10);
            end
            5:
            begin
                send_noise($urandom_range(1, 9));
                make_frame($urandom_range(0, 999999));
                send_span(0, 10);
            end
            6: send_noise($urandom_range(1, 20));
            7, 8: send_ticks($urandom_range(1, 30));
            9:
            begin
                // A frame cut short; the next frame lands behind its tail.
                make_frame($urandom_range(0, 999999));
                send_span(0, $urandom_range(2, 9));
            end
            default:
            begin
                make_frame($urandom_range(0, 999999));
                frm[3] = "E";
                frm[4] = "R";
                frm[5] = "R";
                seal_frame();
                send_span(0, 10);
            end
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = arfp_pkg::KIND_BYTE;
        rx_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = arfp_pkg::REG_OFFSET_CM;
        cfg_data = '0;
        burst_left = 0;
        gap_max = 6;
        sent_items = 0;
        chunks_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(arfp_pkg::REG_OFFSET_CM, 32'h0000_7FFF);
        write_reg(arfp_pkg::REG_TIMEOUT_TICK, 32'd5);
        make_frame(999999);
        send_span(0, 10);
        make_frame(123456);
        frm[10] = frm[10] + 8'd1;
        send_span(0, 10);
        make_frame(0);
        frm[3] = "E";
        frm[4] = "R";
        frm[5] = "R";
        seal_frame();
        send_span(0, 10);
        make_frame(500);
        frm[6] = ",";
        seal_frame();
        send_span(0, 10);
        // The timeout is reported once, and again only after a good frame.
        send_ticks(7);
        make_frame(42);
        send_span(0, 10);
        send_ticks(6);
        // Header found at offset 2 after a partial header.
        send_item(arfp_pkg::KIND_BYTE, arfp_pkg::HDR0);
        send_item(arfp_pkg::KIND_BYTE, arfp_pkg::HDR1);
        make_frame(77001);
        send_span(0, 10);
        // No header in a full buffer; the kept tail starts the next frame.
        repeat (9) send_item(arfp_pkg::KIND_BYTE, 8'h00);
        send_span(0, 1);
        send_span(2, 10);
        repeat (8) send_item(arfp_pkg::KIND_BYTE, 8'hFF);
        send_span(0, 10);

        settle();
        write_reg(arfp_pkg::REG_OFFSET_CM, 32'h0000_8000);
        write_reg(arfp_pkg::REG_TIMEOUT_TICK, 32'd0);
        make_frame(0);
        send_span(0, 10);
        send_ticks(2);
        settle();
        write_reg(arfp_pkg::REG_TIMEOUT_TICK, 32'hFFFF_FFFF);
        make_frame(31415);
        send_span(0, 10);
        send_ticks(3);

        while (sent_items < ITEM_TARGET)
        begin
            settle();
            case ($urandom_range(0, 5))
                0: write_reg(arfp_pkg::REG_OFFSET_CM, 32'h0000_7FFF);
                1: write_reg(arfp_pkg::REG_OFFSET_CM, 32'h0000_8000);
                2: write_reg(arfp_pkg::REG_OFFSET_CM, 32'h0000_0000);
                default: write_reg(arfp_pkg::REG_OFFSET_CM, {16'h0000, 16'($urandom)});
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(arfp_pkg::REG_TIMEOUT_TICK, 32'd1);
                1: write_reg(arfp_pkg::REG_TIMEOUT_TICK, 32'hFFFF_FFFF);
                default: write_reg(arfp_pkg::REG_TIMEOUT_TICK, $urandom_range(2, 40));
            endcase
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            chunks_left = $urandom_range(10, 25);
            while ((chunks_left > 0) && (sent_items < ITEM_TARGET))
            begin
                random_chunk();
                chunks_left--;
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/arfp_pkg.sv
src/arfp_front.sv
src/arfp_back.sv
src/ascii_range_frame_parser_core.sv
dv/range_reading_checker.sv
dv/ascii_range_frame_parser_core_tb.sv
